// ===== rtl/vesel_pkg.sv =====
package vesel_pkg;

   localparam int LIST_DEPTH = 256;
   localparam int INDEX_BITS = 16;
   localparam int VALUE_BITS = 32;
   localparam int SLOT_BITS = 8;
   localparam int ADDR_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int PTR_BITS = $clog2(LIST_DEPTH + 1);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      MODE_ALL     = 3'd0,
      MODE_ONE     = 3'd1,
      MODE_RANGE   = 3'd2,
      MODE_ABOVE   = 3'd3,
      MODE_BELOW   = 3'd4,
      MODE_BETWEEN = 3'd5,
      MODE_LIST    = 3'd6
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE        = 3'd0,
      CSR_LOWER_LIMIT = 3'd1,
      CSR_UPPER_LIMIT = 3'd2,
      CSR_RANGE_FIRST = 3'd3,
      CSR_RANGE_FINAL = 3'd4,
      CSR_RANGE_STEP  = 3'd5,
      CSR_LIST_LENGTH = 3'd6
   } csr_index_type;

   typedef struct packed {
      mode_type                      mode;
      logic signed [VALUE_BITS-1:0]  lower_limit;
      logic signed [VALUE_BITS-1:0]  upper_limit;
      logic [INDEX_BITS-1:0]         range_first;
      logic [INDEX_BITS-1:0]         range_last;
      logic [INDEX_BITS-1:0]         step_minus_one;
      logic [PTR_BITS-1:0]           list_length;
   } cfg_type;

   typedef struct packed {
      logic                          func;
      logic [INDEX_BITS-1:0]         elem_index;
      logic signed [VALUE_BITS-1:0]  elem_value;
      logic                          elem_last;
      logic [SLOT_BITS-1:0]          list_slot;
      logic [INDEX_BITS-1:0]         list_entry;
   } item_type;

endpackage

// ===== rtl/vesel_cfg.sv =====
module vesel_cfg (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [vesel_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [vesel_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output vesel_pkg::cfg_type                     cfg
);

   vesel_pkg::cfg_type cfg_ff;
   vesel_pkg::cfg_type cfg_in;
   logic [vesel_pkg::INDEX_BITS-1:0] step_raw;

   assign step_raw = csr_data[vesel_pkg::INDEX_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (vesel_pkg::csr_index_type'(csr_index))
            vesel_pkg::CSR_MODE:
               cfg_in.mode = vesel_pkg::mode_type'(csr_data[2:0]);
            vesel_pkg::CSR_LOWER_LIMIT:
               cfg_in.lower_limit = csr_data[vesel_pkg::VALUE_BITS-1:0];
            vesel_pkg::CSR_UPPER_LIMIT:
               cfg_in.upper_limit = csr_data[vesel_pkg::VALUE_BITS-1:0];
            vesel_pkg::CSR_RANGE_FIRST:
               cfg_in.range_first = csr_data[vesel_pkg::INDEX_BITS-1:0];
            vesel_pkg::CSR_RANGE_FINAL:
               cfg_in.range_last = csr_data[vesel_pkg::INDEX_BITS-1:0];
            vesel_pkg::CSR_RANGE_STEP:
               // a zero stride behaves as one
               cfg_in.step_minus_one = (step_raw == '0) ? '0 : step_raw - 1'b1;
            vesel_pkg::CSR_LIST_LENGTH: begin
               // clip to the store depth at write time
               if (csr_data > vesel_pkg::CSR_DATA_BITS'(vesel_pkg::LIST_DEPTH)) begin
                  cfg_in.list_length = vesel_pkg::PTR_BITS'(vesel_pkg::LIST_DEPTH);
               end else begin
                  cfg_in.list_length = csr_data[vesel_pkg::PTR_BITS-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/vesel_list_mem.sv =====
module vesel_list_mem (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [vesel_pkg::ADDR_BITS-1:0]     wr_addr,
   input  logic [vesel_pkg::INDEX_BITS-1:0]    wr_data,
   input  logic [vesel_pkg::ADDR_BITS-1:0]     rd_addr,
   output logic [vesel_pkg::INDEX_BITS-1:0]    rd_data
);

   logic [vesel_pkg::INDEX_BITS-1:0] mem [vesel_pkg::LIST_DEPTH];
   logic [vesel_pkg::INDEX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-first: a load to the entry being fetched shows up at once
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/vesel_core.sv =====
module vesel_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  vesel_pkg::item_type                 item,
   input  vesel_pkg::cfg_type                  cfg,
   input  logic [vesel_pkg::INDEX_BITS-1:0]    list_data,
   output logic [vesel_pkg::ADDR_BITS-1:0]     list_rd_addr,
   output logic                                list_wr_en,
   output logic [vesel_pkg::ADDR_BITS-1:0]     list_wr_addr,
   output logic                                picked
);

   logic [vesel_pkg::PTR_BITS-1:0]   ptr_ff;
   logic [vesel_pkg::PTR_BITS-1:0]   ptr_in;
   logic [vesel_pkg::INDEX_BITS-1:0] stride_ff;
   logic [vesel_pkg::INDEX_BITS-1:0] stride_in;
   logic                             in_range;
   logic                             above;
   logic                             below;
   logic                             list_hit;
   logic                             data_beat;

   assign data_beat = advance && !item.func;

   assign in_range = (item.elem_index >= cfg.range_first) &&
                     (item.elem_index <= cfg.range_last);
   assign above = item.elem_value > cfg.lower_limit;
   assign below = item.elem_value < cfg.upper_limit;
   assign list_hit = (ptr_ff < cfg.list_length) && (list_data == item.elem_index);

   always_comb begin
      picked = 1'b0;
      stride_in = stride_ff;
      ptr_in = ptr_ff;
      unique case (cfg.mode)
         vesel_pkg::MODE_ONE:
            picked = (item.elem_index == cfg.range_first);
         vesel_pkg::MODE_RANGE: begin
            if (in_range) begin
               if (stride_ff == '0) begin
                  picked = 1'b1;
                  stride_in = cfg.step_minus_one;
               end else begin
                  stride_in = stride_ff - 1'b1;
               end
            end
         end
         vesel_pkg::MODE_ABOVE:
            picked = above;
         vesel_pkg::MODE_BELOW:
            picked = below;
         vesel_pkg::MODE_BETWEEN:
            picked = above && below;
         vesel_pkg::MODE_LIST: begin
            if (list_hit) begin
               picked = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default:
            picked = 1'b1;
      endcase
      if (item.elem_last) begin
         stride_in = '0;
         ptr_in = '0;
      end
      if (!data_beat) begin
         stride_in = stride_ff;
         ptr_in = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         stride_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         stride_ff <= stride_in;
      end
   end

   // prefetch the entry the pointer will sit on for the next beat
   assign list_rd_addr = vesel_pkg::ADDR_BITS'(ptr_in);

   assign list_wr_en = advance && item.func &&
                       (32'(item.list_slot) < 32'(vesel_pkg::LIST_DEPTH));
   assign list_wr_addr = vesel_pkg::ADDR_BITS'(item.list_slot);

endmodule

// ===== rtl/vector_element_selector_top.sv =====
// Stream filter over vector elements. One beat is taken every cycle unless
// req_stall holds it; a data element passes an input register and then a
// result register, and a list load beat yields nothing. Selection
// compares, the stride counter and the list match all sit in the one stage
// between those registers; the list entry under the pointer comes from a
// registered read port of the 256-entry store that is fetched at the
// pointer's next value, so list mode keeps full rate. The store has no reset
// and no clearing pass; load the list sorted and without repeats before use.
// The stride counter and list pointer return to zero after a last element.
module vector_element_selector_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_func,
   input  logic [vesel_pkg::INDEX_BITS-1:0]          req_elem_index,
   input  logic signed [vesel_pkg::VALUE_BITS-1:0]   req_elem_value,
   input  logic                                      req_elem_last,
   input  logic [vesel_pkg::SLOT_BITS-1:0]           req_list_slot,
   input  logic [vesel_pkg::INDEX_BITS-1:0]          req_list_entry,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_picked,
   output logic [vesel_pkg::INDEX_BITS-1:0]          rsp_out_index,
   output logic signed [vesel_pkg::VALUE_BITS-1:0]   rsp_out_value,
   output logic                                      rsp_out_last,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [vesel_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [vesel_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   vesel_pkg::cfg_type  cfg;
   vesel_pkg::item_type s1_ff;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_picked_ff;
   logic [vesel_pkg::INDEX_BITS-1:0]         rsp_index_ff;
   logic signed [vesel_pkg::VALUE_BITS-1:0]  rsp_value_ff;
   logic                rsp_last_ff;
   logic                out_free;
   logic                advance;
   logic                picked;
   logic [vesel_pkg::ADDR_BITS-1:0]  rd_addr;
   logic [vesel_pkg::INDEX_BITS-1:0] rd_data;
   logic                wr_en;
   logic [vesel_pkg::ADDR_BITS-1:0]  wr_addr;

   assign csr_ready = 1'b1;

   vesel_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // load beats never wait for the result side
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = s1_valid_ff && (s1_ff.func || out_free);
   assign req_stall = s1_valid_ff && !advance;

   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ff.func <= req_func;
         s1_ff.elem_index <= req_elem_index;
         s1_ff.elem_value <= req_elem_value;
         s1_ff.elem_last <= req_elem_last;
         s1_ff.list_slot <= req_list_slot;
         s1_ff.list_entry <= req_list_entry;
      end
   end

   vesel_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (s1_ff),
      .cfg          (cfg),
      .list_data    (rd_data),
      .list_rd_addr (rd_addr),
      .list_wr_en   (wr_en),
      .list_wr_addr (wr_addr),
      .picked       (picked)
   );

   vesel_list_mem u_list_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s1_ff.list_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (advance && !s1_ff.func) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !s1_ff.func) begin
         rsp_picked_ff <= picked;
         rsp_index_ff <= s1_ff.elem_index;
         rsp_value_ff <= s1_ff.elem_value;
         rsp_last_ff <= s1_ff.elem_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_picked = rsp_picked_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

// ===== sim/vector_element_selector_top_tb.sv =====
`timescale 1ns / 100ps

module vector_element_selector_top_tb;
   import vesel_pkg::*;

   localparam logic       FUNC_DATA       = 1'b0;
   localparam logic       FUNC_LOAD       = 1'b1;
   localparam logic [2:0] MODE_UNUSED     = 3'd7;
   localparam int         LIST_LENGTH_MAX = 2 ** PTR_BITS - 1;
   localparam int         RANDOM_ITEMS    = 2000;
   localparam int         SETTLE_CYCLES   = 6;
   localparam int         CALM_DEPTH      = 200;
   localparam int         CYCLE_LIMIT     = 400000;

   typedef enum logic {OP_ELEMENT, OP_REGISTER} op_kind_type;

   typedef struct {
      op_kind_type   kind;
      item_type      item;
      csr_index_type reg_idx;
      logic [31:0]   reg_data;
   } stim_beat_type;

   typedef struct packed {
      logic                         picked;
      logic [INDEX_BITS-1:0]        index;
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
   } elem_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_func = FUNC_DATA;
   logic [INDEX_BITS-1:0]         req_elem_index = '0;
   logic signed [VALUE_BITS-1:0]  req_elem_value = '0;
   logic                          req_elem_last = 1'b0;
   logic [SLOT_BITS-1:0]          req_list_slot = '0;
   logic [INDEX_BITS-1:0]         req_list_entry = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_picked;
   logic [INDEX_BITS-1:0]         rsp_out_index;
   logic signed [VALUE_BITS-1:0]  rsp_out_value;
   logic                          rsp_out_last;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   vector_element_selector_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .req_elem_last  (req_elem_last),
      .req_list_slot  (req_list_slot),
      .req_list_entry (req_list_entry),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_picked     (rsp_picked),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // selector copy of the block
   logic [2:0]                   sel_mode = MODE_ALL;
   logic signed [VALUE_BITS-1:0] sel_lower = '0;
   logic signed [VALUE_BITS-1:0] sel_upper = '0;
   logic [INDEX_BITS-1:0]        sel_first = '0;
   logic [INDEX_BITS-1:0]        sel_stop = '0;
   logic [INDEX_BITS-1:0]        sel_step = INDEX_BITS'(1);
   logic [31:0]                  sel_len = '0;
   logic [INDEX_BITS-1:0]        index_list [0:LIST_DEPTH-1];
   logic [PTR_BITS-1:0]          list_ptr = '0;
   logic [INDEX_BITS-1:0]        stride_cnt = '0;

   stim_beat_type   pending_beats [$];
   elem_result_type expected_elems [$];
   int              fail_count = 0;
   int              items_made = 0;
   int              cycle_count = 0;
   logic            calm = 1'b0;

   task automatic apply_register(input csr_index_type idx, input logic [31:0] data);
      case (idx)
         CSR_MODE:        sel_mode = data[2:0];
         CSR_LOWER_LIMIT: sel_lower = data;
         CSR_UPPER_LIMIT: sel_upper = data;
         CSR_RANGE_FIRST: sel_first = data[INDEX_BITS-1:0];
         CSR_RANGE_FINAL: sel_stop = data[INDEX_BITS-1:0];
         CSR_RANGE_STEP:  sel_step = data[INDEX_BITS-1:0];
         CSR_LIST_LENGTH: sel_len = data;
         default: ;
      endcase
   endtask

   task automatic select_element(input item_type it);
      logic                  picked;
      logic [PTR_BITS:0]     eff_len;
      logic [INDEX_BITS-1:0] step;
      elem_result_type       res;
      if (it.func == FUNC_LOAD) begin
         if (int'(it.list_slot) < LIST_DEPTH) index_list[it.list_slot] = it.list_entry;
         return;
      end
      picked = 1'b0;
      case (sel_mode)
         MODE_ONE: picked = (it.elem_index == sel_first);
         MODE_RANGE: begin
            if (it.elem_index >= sel_first && it.elem_index <= sel_stop) begin
               if (stride_cnt == '0) begin
                  step = (sel_step == '0) ? INDEX_BITS'(1) : sel_step;
                  picked = 1'b1;
                  stride_cnt = step - 1'b1;
               end else begin
                  stride_cnt = stride_cnt - 1'b1;
               end
            end
         end
         MODE_ABOVE: picked = (it.elem_value > sel_lower);
         MODE_BELOW: picked = (it.elem_value < sel_upper);
         MODE_BETWEEN: picked = (it.elem_value > sel_lower) && (it.elem_value < sel_upper);
         MODE_LIST: begin
            eff_len = (sel_len > LIST_DEPTH) ? (PTR_BITS+1)'(LIST_DEPTH) : sel_len[PTR_BITS:0];
            if (list_ptr < eff_len) begin
               if (index_list[list_ptr] == it.elem_index) begin
                  picked = 1'b1;
                  list_ptr = list_ptr + 1'b1;
               end
            end
         end
         default: picked = 1'b1;
      endcase
      if (it.elem_last) begin
         stride_cnt = '0;
         list_ptr = '0;
      end
      res.picked = picked;
      res.index = it.elem_index;
      res.value = it.elem_value;
      res.last = it.elem_last;
      expected_elems.insert(expected_elems.size(), res);
   endtask

   task automatic push_element(input logic [15:0] idx, input logic [31:0] val, input logic last);
      stim_beat_type b;
      b.kind = OP_ELEMENT;
      b.item.func = FUNC_DATA;
      b.item.elem_index = idx;
      b.item.elem_value = val;
      b.item.elem_last = last;
      b.item.list_slot = SLOT_BITS'($urandom);
      b.item.list_entry = INDEX_BITS'($urandom);
      b.reg_idx = CSR_MODE;
      b.reg_data = '0;
      pending_beats.insert(pending_beats.size(), b);
      items_made++;
   endtask

   task automatic push_load(input logic [7:0] slot, input logic [15:0] entry);
      stim_beat_type b;
      b.kind = OP_ELEMENT;
      b.item.func = FUNC_LOAD;
      b.item.elem_index = INDEX_BITS'($urandom);
      b.item.elem_value = $urandom;
      b.item.elem_last = 1'($urandom_range(0, 1));
      b.item.list_slot = slot;
      b.item.list_entry = entry;
      b.reg_idx = CSR_MODE;
      b.reg_data = '0;
      pending_beats.insert(pending_beats.size(), b);
      items_made++;
   endtask

   task automatic push_reg(input csr_index_type idx, input logic [31:0] data);
      stim_beat_type b;
      b.kind = OP_REGISTER;
      b.item = '0;
      b.reg_idx = idx;
      b.reg_data = data;
      pending_beats.insert(pending_beats.size(), b);
   endtask

   // mix of full range, extremes and small Q16.16 values near zero
   function automatic logic [31:0] random_value();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         default: v = $urandom_range(0, 8) * 32'h8000 - 32'h2_0000;
      endcase
      return v;
   endfunction

   // driver
   stim_beat_type cur_beat;
   bit            req_busy;
   bit            csr_busy;
   int            gap_left = 0;
   int            quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         req_busy = req_valid;
         csr_busy = csr_valid;
         if (req_valid && !req_stall) begin
            select_element(cur_beat.item);
            req_busy = 1'b0;
            quiet_cycles = 0;
            if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
         end
         if (csr_valid && csr_ready) begin
            apply_register(cur_beat.reg_idx, cur_beat.reg_data);
            csr_busy = 1'b0;
         end
         if (expected_elems.size() != 0) quiet_cycles = 0;
         else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
         if (!req_busy && !csr_busy) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_beats.size() != 0) begin
               if (pending_beats[0].kind == OP_ELEMENT) begin
                  cur_beat = pending_beats.pop_front();
                  req_busy = 1'b1;
                  req_func <= cur_beat.item.func;
                  req_elem_index <= cur_beat.item.elem_index;
                  req_elem_value <= cur_beat.item.elem_value;
                  req_elem_last <= cur_beat.item.elem_last;
                  req_list_slot <= cur_beat.item.list_slot;
                  req_list_entry <= cur_beat.item.list_entry;
               end else if (quiet_cycles >= SETTLE_CYCLES) begin
                  // registers change only once the pipeline has drained
                  cur_beat = pending_beats.pop_front();
                  csr_busy = 1'b1;
                  csr_index <= cur_beat.reg_idx;
                  csr_data <= cur_beat.reg_data;
               end
            end
         end
         req_valid <= req_busy;
         csr_valid <= csr_busy;
         calm <= (pending_beats.size() < CALM_DEPTH);
      end
   end

   // monitor
   elem_result_type got_exp;
   int              stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_elems.size() == 0) begin
               $display("%0t: unexpected beat, expected none actual index %h", $time,
                        rsp_out_index);
               fail_count++;
            end else begin
               got_exp = expected_elems.pop_front();
               if (rsp_picked !== got_exp.picked) begin
                  $display("%0t: picked expected %b actual %b", $time, got_exp.picked,
                           rsp_picked);
                  fail_count++;
               end
               if (rsp_out_index !== got_exp.index) begin
                  $display("%0t: out_index expected %h actual %h", $time, got_exp.index,
                           rsp_out_index);
                  fail_count++;
               end
               if (rsp_out_value !== got_exp.value) begin
                  $display("%0t: out_value expected %h actual %h", $time, got_exp.value,
                           rsp_out_value);
                  fail_count++;
               end
               if (rsp_out_last !== got_exp.last) begin
                  $display("%0t: out_last expected %b actual %b", $time, got_exp.last,
                           rsp_out_last);
                  fail_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("vector_element_selector_top: mismatch");
         $finish;
      end
   end

   initial begin
      int   n;
      int   list_len;
      int   v;
      int   r;
      logic [2:0] mode_pick;

      // reset settings pass everything
      push_element(16'hFFFF, 32'h7FFF_FFFF, 1'b1);
      push_element(16'h0000, 32'h8000_0000, 1'b0);
      push_reg(CSR_MODE, 32'(MODE_ONE));
      push_reg(CSR_RANGE_FIRST, 32'hFFFF);
      push_element(16'h0001, 32'h0, 1'b0);
      push_element(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      // zero stride behaves as a stride of one
      push_reg(CSR_MODE, 32'(MODE_RANGE));
      push_reg(CSR_RANGE_FIRST, 1);
      push_reg(CSR_RANGE_FINAL, 3);
      push_reg(CSR_RANGE_STEP, 0);
      for (int i = 0; i < 5; i++) push_element(16'(i), 32'(i), i == 4);
      push_reg(CSR_RANGE_FIRST, 0);
      push_reg(CSR_RANGE_FINAL, 32'hFFFF);
      push_reg(CSR_RANGE_STEP, 32'hFFFF);
      push_element(16'd0, 32'h1_0000, 1'b0);
      push_element(16'd1, 32'h2_0000, 1'b1);
      // first above last selects nothing
      push_reg(CSR_RANGE_FIRST, 3);
      push_reg(CSR_RANGE_FINAL, 2);
      push_element(16'd2, 32'h0, 1'b0);
      push_element(16'd3, 32'h0, 1'b1);
      push_reg(CSR_MODE, 32'(MODE_ABOVE));
      push_reg(CSR_LOWER_LIMIT, 32'h7FFF_FFFF);
      push_element(16'd0, 32'h7FFF_FFFF, 1'b0);
      push_reg(CSR_MODE, 32'(MODE_BELOW));
      push_reg(CSR_UPPER_LIMIT, 32'h8000_0000);
      push_element(16'd1, 32'h8000_0000, 1'b0);
      // equal limits select nothing
      push_reg(CSR_MODE, 32'(MODE_BETWEEN));
      push_reg(CSR_LOWER_LIMIT, 0);
      push_reg(CSR_UPPER_LIMIT, 0);
      push_element(16'd2, 32'h0, 1'b1);
      push_reg(CSR_MODE, 32'(MODE_UNUSED));
      push_element(16'd0, $urandom, 1'b1);
      push_reg(CSR_MODE, 32'(MODE_LIST));
      push_reg(CSR_LIST_LENGTH, 3);
      push_load(8'd0, 16'd1);
      push_load(8'd1, 16'd2);
      push_load(8'd2, 16'd4);
      for (int i = 0; i < 5; i++) push_element(16'(i), random_value(), i == 4);

      // whole store loaded, then run the pointer off its end; also a length past the depth
      items_made = 0;
      push_reg(CSR_LIST_LENGTH, LIST_DEPTH);
      for (int k = 0; k < LIST_DEPTH; k++) push_load(8'(k), 16'(k));
      for (int i = 0; i < LIST_DEPTH + 4; i++)
         push_element(16'(i), random_value(), i == LIST_DEPTH + 3);
      push_reg(CSR_LIST_LENGTH, LIST_LENGTH_MAX);
      for (int i = 0; i < LIST_DEPTH + 2; i++)
         push_element(16'(i), random_value(), i == LIST_DEPTH + 1);

      while (items_made < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         mode_pick = (r < 8) ? r[2:0] : ((r == 8) ? MODE_RANGE : MODE_LIST);
         push_reg(CSR_MODE, 32'(mode_pick));
         if ($urandom_range(0, 1)) push_reg(CSR_LOWER_LIMIT, random_value());
         if ($urandom_range(0, 1)) push_reg(CSR_UPPER_LIMIT, random_value());
         if ($urandom_range(0, 1)) push_reg(CSR_RANGE_FIRST, $urandom_range(0, 10));
         if ($urandom_range(0, 1))
            push_reg(CSR_RANGE_FINAL, ($urandom_range(0, 9) == 0) ? 32'hFFFF : $urandom_range(0, 40));
         if ($urandom_range(0, 1))
            push_reg(CSR_RANGE_STEP, ($urandom_range(0, 9) == 0) ? 32'hFFFF : $urandom_range(0, 5));
         list_len = $urandom_range(0, 12);
         push_reg(CSR_LIST_LENGTH, list_len);
         if (mode_pick == MODE_LIST) begin
            // sorted, no repeats
            v = $urandom_range(0, 3);
            for (int k = 0; k < list_len; k++) begin
               push_load(8'(k), 16'(v));
               v += $urandom_range(1, 4);
            end
         end
         repeat ($urandom_range(1, 3)) begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
               r = $urandom_range(0, 29);
               if (r == 0)
                  push_element(16'($urandom), random_value(), 1'($urandom_range(0, 1)));
               else if (r == 1)
                  push_load(8'($urandom_range(list_len, LIST_DEPTH - 1)), 16'($urandom));
               // occasionally the vector is left open
               push_element(16'(i), random_value(), (i == n - 1) && (r != 2));
            end
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid || csr_valid) @(posedge clock);
      while (expected_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_elems.size() == 0) begin
         $display("vector_element_selector_top: match");
      end else begin
         $display("vector_element_selector_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== vector_element_selector_top.f =====
rtl/vesel_pkg.sv
rtl/vesel_cfg.sv
rtl/vesel_list_mem.sv
rtl/vesel_core.sv
rtl/vector_element_selector_top.sv
sim/vector_element_selector_top_tb.sv
